FILE: src/script_line_lexer_assert.svh
// Assertion macros for the script line lexer checker.
// Needs a clock named clk and a synchronous reset named rst in scope.
`ifndef SCRIPT_LINE_LEXER_ASSERT_SVH
`define SCRIPT_LINE_LEXER_ASSERT_SVH

// Same-cycle implication, skipped while in reset.
`define SLL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("script_line_lexer check failed");

// Next-cycle implication, skipped while in reset.
`define SLL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("script_line_lexer check failed");

`endif

FILE: src/sll_pkg.sv
// Shared types and codes for the script line lexer.
// No dependencies; used by sll_step, script_line_lexer and sll_checker.
`timescale 1ns / 1ps

package sll_pkg;

  // Lexer modes, one-hot.
  typedef enum logic [7:0] {
    MODE_IDLE    = 8'b0000_0001,
    MODE_NAME    = 8'b0000_0010,
    MODE_INT     = 8'b0000_0100,
    MODE_FRAC    = 8'b0000_1000,
    MODE_STR     = 8'b0001_0000,
    MODE_ESC     = 8'b0010_0000,
    MODE_SYM     = 8'b0100_0000,
    MODE_COMMENT = 8'b1000_0000
  } mode_t;

  // Token kinds.
  localparam logic [1:0] K_NAME = 2'd0;
  localparam logic [1:0] K_NUM  = 2'd1;
  localparam logic [1:0] K_STR  = 2'd2;
  localparam logic [1:0] K_SYM  = 2'd3;

  // Brace kinds.
  localparam logic [1:0] BRACE_NONE  = 2'd0;
  localparam logic [1:0] BRACE_OPEN  = 2'd1;
  localparam logic [1:0] BRACE_CLOSE = 2'd2;

  localparam int unsigned MaxResults = 4;

  typedef struct packed {
    mode_t      mode;
    logic [7:0] held_char;
    logic       held_valid;
    logic [1:0] held_kind;
    logic [7:0] pending_symbol;
    logic [7:0] current_first_char;
    logic [7:0] last_token_first_char;
    logic       line_has_token;
  } lex_state_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic [1:0] tok_kind;
    logic       tok_last;
    logic       empty_string;
    logic       line_done;
    logic [1:0] brace_kind;
  } result_t;

  typedef result_t [MaxResults-1:0] res_set_t;

endpackage

FILE: src/sll_step.sv
// Next-state and result logic of the script line lexer for one character.
// Purely combinational; depends on sll_pkg.
`timescale 1ns / 1ps

module sll_step (
  input  sll_pkg::lex_state_t st_cur,
  input  logic [7:0]          ch,
  output sll_pkg::lex_state_t st_next,
  output sll_pkg::res_set_t   results,
  output logic [2:0]          res_cnt
);

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef struct packed {
    sll_pkg::lex_state_t st;
    sll_pkg::res_set_t   res;
    logic [2:0]          cnt;
  } work_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) || (c == 8'h5F);
  endfunction

  function automatic logic is_symbol(logic [7:0] c);
    return (c == 8'h21) || (c == 8'h25) || (c == 8'h26) || (c == 8'h7C) ||
           (c == 8'h2C) || (c == 8'h2B) || (c == 8'h2D) || (c == 8'h2A) ||
           (c == CH_SLASH) || (c == CH_EQ) || (c == 8'h3C) || (c == 8'h3E) ||
           (c == 8'h28) || (c == CH_RPAREN) || (c == CH_LBRACE) ||
           (c == CH_RBRACE) || (c == CH_DOT) || (c == 8'h40);
  endfunction

  // Resolved escape byte, zero when the byte has no escape.
  function automatic logic [7:0] escape_of(logic [7:0] c);
    logic [7:0] e;
    unique case (c)
      8'h62:     e = 8'h08;
      8'h66:     e = 8'h0C;
      8'h6E:     e = CH_LF;
      8'h72:     e = CH_CR;
      8'h74:     e = CH_TAB;
      CH_QUOTE:  e = CH_QUOTE;
      CH_BSLASH: e = CH_BSLASH;
      default:   e = CH_NUL;
    endcase
    return e;
  endfunction

  function automatic work_t put(work_t w, logic [7:0] c, logic [1:0] kind, logic last,
                                logic empty, logic done, logic [1:0] brace);
    work_t o;
    o = w;
    if (o.cnt < 3'(sll_pkg::MaxResults)) begin
      o.res[o.cnt[1:0]] = '{out_char: c, tok_kind: kind, tok_last: last,
                             empty_string: empty, line_done: done, brace_kind: brace};
      o.cnt = o.cnt + 3'd1;
    end
    return o;
  endfunction

  function automatic work_t push_char(work_t w, logic [7:0] c, logic [1:0] kind);
    work_t o;
    o = w;
    if (o.st.held_valid) begin
      o = put(o, o.st.held_char, o.st.held_kind, 1'b0, 1'b0, 1'b0, sll_pkg::BRACE_NONE);
    end else begin
      o.st.current_first_char = c;
    end
    o.st.held_char  = c;
    o.st.held_kind  = kind;
    o.st.held_valid = 1'b1;
    return o;
  endfunction

  function automatic work_t finish_token(work_t w, logic is_string);
    work_t o;
    o = w;
    if (o.st.held_valid) begin
      o = put(o, o.st.held_char, o.st.held_kind, 1'b1, 1'b0, 1'b0, sll_pkg::BRACE_NONE);
      o.st.last_token_first_char = o.st.current_first_char;
    end else if (is_string) begin
      o = put(o, CH_NUL, sll_pkg::K_STR, 1'b1, 1'b1, 1'b0, sll_pkg::BRACE_NONE);
      o.st.last_token_first_char = CH_NUL;
    end else begin
      return o;
    end
    o.st.line_has_token = 1'b1;
    o.st.held_valid     = 1'b0;
    o.st.mode           = sll_pkg::MODE_IDLE;
    return o;
  endfunction

  function automatic work_t end_line(work_t w, sll_pkg::mode_t next_mode);
    work_t      o;
    logic [1:0] brace;
    o     = w;
    brace = sll_pkg::BRACE_NONE;
    if (o.st.line_has_token) begin
      if (o.st.last_token_first_char == CH_LBRACE) begin
        brace = sll_pkg::BRACE_OPEN;
      end else if (o.st.last_token_first_char == CH_RBRACE) begin
        brace = sll_pkg::BRACE_CLOSE;
      end
    end
    o = put(o, CH_NUL, sll_pkg::K_NAME, 1'b0, 1'b0, 1'b1, brace);
    o.st.line_has_token        = 1'b0;
    o.st.last_token_first_char = CH_NUL;
    o.st.held_valid            = 1'b0;
    o.st.mode                  = next_mode;
    return o;
  endfunction

  function automatic work_t start_from_idle(work_t w, logic [7:0] c);
    work_t o;
    o         = w;
    o.st.mode = sll_pkg::MODE_IDLE;
    if ((c == CH_SPACE) || (c == CH_TAB)) begin
      return o;
    end
    if (is_digit(c)) begin
      o         = push_char(o, c, sll_pkg::K_NUM);
      o.st.mode = sll_pkg::MODE_INT;
    end else if (is_alpha(c)) begin
      o         = push_char(o, c, sll_pkg::K_NAME);
      o.st.mode = sll_pkg::MODE_NAME;
    end else if (c == CH_QUOTE) begin
      o.st.held_valid         = 1'b0;
      o.st.current_first_char = CH_NUL;
      o.st.mode               = sll_pkg::MODE_STR;
    end else if (is_symbol(c)) begin
      o.st.pending_symbol     = c;
      o.st.current_first_char = c;
      o.st.mode               = sll_pkg::MODE_SYM;
    end else begin
      o = end_line(o, sll_pkg::MODE_IDLE);
    end
    return o;
  endfunction

  always_comb begin
    work_t      w;
    logic [7:0] esc;
    logic [7:0] p;
    w.st  = st_cur;
    w.res = '0;
    w.cnt = 3'd0;
    esc   = escape_of(ch);
    p     = st_cur.pending_symbol;
    unique case (st_cur.mode)
      sll_pkg::MODE_NAME: begin
        if (is_alpha(ch) || is_digit(ch)) begin
          w = push_char(w, ch, sll_pkg::K_NAME);
        end else begin
          w = finish_token(w, 1'b0);
          w = start_from_idle(w, ch);
        end
      end
      sll_pkg::MODE_INT: begin
        if (is_digit(ch)) begin
          w = push_char(w, ch, sll_pkg::K_NUM);
        end else if (ch == CH_DOT) begin
          w         = push_char(w, ch, sll_pkg::K_NUM);
          w.st.mode = sll_pkg::MODE_FRAC;
        end else begin
          w = finish_token(w, 1'b0);
          w = start_from_idle(w, ch);
        end
      end
      sll_pkg::MODE_FRAC: begin
        if (is_digit(ch)) begin
          w = push_char(w, ch, sll_pkg::K_NUM);
        end else begin
          w = finish_token(w, 1'b0);
          w = start_from_idle(w, ch);
        end
      end
      sll_pkg::MODE_STR: begin
        if (ch == CH_QUOTE) begin
          w = finish_token(w, 1'b1);
        end else if (ch == CH_NUL) begin
          w = finish_token(w, 1'b1);
          w = end_line(w, sll_pkg::MODE_IDLE);
        end else if (ch == CH_BSLASH) begin
          w.st.mode = sll_pkg::MODE_ESC;
        end else begin
          w = push_char(w, ch, sll_pkg::K_STR);
        end
      end
      sll_pkg::MODE_ESC: begin
        if (esc != CH_NUL) begin
          w         = push_char(w, esc, sll_pkg::K_STR);
          w.st.mode = sll_pkg::MODE_STR;
        end else begin
          // unknown escape: keep the backslash as content
          w = push_char(w, CH_BSLASH, sll_pkg::K_STR);
          if (ch == CH_NUL) begin
            w = finish_token(w, 1'b1);
            w = end_line(w, sll_pkg::MODE_IDLE);
          end else begin
            w         = push_char(w, ch, sll_pkg::K_STR);
            w.st.mode = sll_pkg::MODE_STR;
          end
        end
      end
      sll_pkg::MODE_SYM: begin
        if ((p == CH_SLASH) && (ch == CH_SLASH)) begin
          w = end_line(w, sll_pkg::MODE_COMMENT);
        end else if (((ch == CH_EQ) || (ch == p)) && (p != CH_RPAREN)) begin
          w = put(w, p, sll_pkg::K_SYM, 1'b0, 1'b0, 1'b0, sll_pkg::BRACE_NONE);
          w = put(w, ch, sll_pkg::K_SYM, 1'b1, 1'b0, 1'b0, sll_pkg::BRACE_NONE);
          w.st.last_token_first_char = p;
          w.st.line_has_token        = 1'b1;
          w.st.mode                  = sll_pkg::MODE_IDLE;
        end else begin
          w = put(w, p, sll_pkg::K_SYM, 1'b1, 1'b0, 1'b0, sll_pkg::BRACE_NONE);
          w.st.last_token_first_char = p;
          w.st.line_has_token        = 1'b1;
          w = start_from_idle(w, ch);
        end
      end
      sll_pkg::MODE_COMMENT: begin
        if ((ch == CH_CR) || (ch == CH_LF) || (ch == CH_NUL)) begin
          w.st.mode = sll_pkg::MODE_IDLE;
        end
      end
      default: begin
        w = start_from_idle(w, ch);
      end
    endcase
    st_next = w.st;
    results = w.res;
    res_cnt = w.cnt;
  end

endmodule

FILE: src/script_line_lexer.sv
// Top level of the script line lexer: input register, lexer state, result bundle.
// Depends on sll_pkg and sll_step.
`timescale 1ns / 1ps

// Script line lexer. One raw byte of a script line enters per item on the ch
// channel; token characters leave one per item on the result channel, tagged
// with their kind (name, number, string, symbol) and a last flag that marks
// the final character of each token. Escapes in string literals arrive already
// resolved, an empty string gives one item with empty_string set, and each
// line end gives one item with line_done set and brace_kind taken from the
// first character of the line's last token. A "//" comment ends the line and
// swallows bytes through the next CR, LF or NUL.
// Timing: a byte is captured in the input register, is lexed in one pass
// and lands in a four-slot result bundle that drains on the single result
// port. A plain run of token characters flows at one byte per cycle while
// res_stall is low; a byte that yields more than one result (at most three)
// stalls the input while the bundle drains. A byte's first result leaves
// from the result bundle, which is loaded from the input register.

module script_line_lexer (
  input  logic       clk,
  input  logic       rst,
  // character channel
  input  logic       ch_valid,
  output logic       ch_stall,
  input  logic [7:0] ch,
  // result channel
  output logic       res_valid,
  input  logic       res_stall,
  output logic [7:0] out_char,
  output logic [1:0] tok_kind,
  output logic       tok_last,
  output logic       empty_string,
  output logic       line_done,
  output logic [1:0] brace_kind
);

  // input register
  logic                q_valid;
  logic [7:0]          q_ch;

  // lexer state
  sll_pkg::lex_state_t st;
  sll_pkg::lex_state_t st_next;

  // result bundle from the last lexed byte
  sll_pkg::res_set_t   b_res;
  logic [2:0]          b_left;  // results still to send
  logic [1:0]          b_pos;   // slot of the result on the port

  sll_pkg::res_set_t   step_res;
  logic [2:0]          step_cnt;

  logic                drain;
  logic                bundle_free;
  logic                fire;

  sll_step u_step (
    .st_cur  (st),
    .ch      (q_ch),
    .st_next (st_next),
    .results (step_res),
    .res_cnt (step_cnt)
  );

  assign res_valid = (b_left != 3'd0);
  assign drain     = res_valid && !res_stall;

  // The bundle can take new results when it is empty or its last one leaves this cycle.
  assign bundle_free = (b_left == 3'd0) || ((b_left == 3'd1) && drain);
  assign fire        = q_valid && bundle_free;
  assign ch_stall    = q_valid && !fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (ch_valid && !ch_stall) begin
      q_valid <= 1'b1;
    end else if (fire) begin
      q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ch_valid && !ch_stall) begin
      q_ch <= ch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= '{mode: sll_pkg::MODE_IDLE, held_char: 8'h00, held_valid: 1'b0,
                     held_kind: sll_pkg::K_NAME, pending_symbol: 8'h00,
                     current_first_char: 8'h00, last_token_first_char: 8'h00,
                     line_has_token: 1'b0};
      b_left    <= 3'd0;
      b_pos     <= 2'd0;
    end else if (fire) begin
      st        <= st_next;
      b_left    <= step_cnt;
      b_pos     <= 2'd0;
    end else if (drain) begin
      b_left    <= b_left - 3'd1;
      b_pos     <= b_pos + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      b_res <= step_res;
    end
  end

  assign out_char     = b_res[b_pos].out_char;
  assign tok_kind     = b_res[b_pos].tok_kind;
  assign tok_last     = b_res[b_pos].tok_last;
  assign empty_string = b_res[b_pos].empty_string;
  assign line_done    = b_res[b_pos].line_done;
  assign brace_kind   = b_res[b_pos].brace_kind;

endmodule

FILE: src/sll_checker.sv
// Port-level checker for the script line lexer, bound to the top level.
// Depends on sll_pkg and script_line_lexer_assert.svh.
`timescale 1ns / 1ps
`include "script_line_lexer_assert.svh"

module sll_checker (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_stall,
  input logic [7:0] out_char,
  input logic [1:0] tok_kind,
  input logic       tok_last,
  input logic       empty_string,
  input logic       line_done,
  input logic [1:0] brace_kind
);

  // stalled result holds
  `SLL_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(out_char) && $stable(tok_kind) && $stable(tok_last) && $stable(line_done))

  // line end carries no character
  `SLL_ASSERT_NOW(a_line_done_bare, res_valid && line_done, (out_char == 8'h00) && (tok_kind == sll_pkg::K_NAME) && !tok_last && !empty_string)

  // empty string is a complete string token
  `SLL_ASSERT_NOW(a_empty_str, res_valid && empty_string, (tok_kind == sll_pkg::K_STR) && tok_last && !line_done && (out_char == 8'h00))

  // brace kind only on line end
  `SLL_ASSERT_NOW(a_brace_on_done, res_valid && (brace_kind != sll_pkg::BRACE_NONE), line_done && ((brace_kind == sll_pkg::BRACE_OPEN) || (brace_kind == sll_pkg::BRACE_CLOSE)))

endmodule

bind script_line_lexer sll_checker u_sll_checker (.*);
